/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define WPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that, when true, requires a consequence in the same cycle.
`define WPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/wpd_pkg.sv */
// ---------------------------------------------------------------------------
// WAV to PWM duty package
// Types, codes and constants shared by the parser, the command queue and
// the result emitter.
// ---------------------------------------------------------------------------
package wpd_pkg;

  localparam int DUTY_BITS  = 10;
  localparam int MAX_REPEAT = 8;
  localparam int REP_W      = $clog2(MAX_REPEAT + 1);

  localparam logic [31:0] RATE_RESET   = 32'((125000000 >> DUTY_BITS) / 4);
  localparam logic [3:0]  REPEAT_RESET = 4'd4;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;

  localparam logic [5:0] OFF_RIFF  = 6'd3;
  localparam logic [5:0] OFF_WAVE  = 6'd11;
  localparam logic [5:0] OFF_FMT   = 6'd21;
  localparam logic [5:0] OFF_CHAN  = 6'd23;
  localparam logic [5:0] OFF_RATE  = 6'd27;
  localparam logic [5:0] OFF_BITS  = 6'd35;
  localparam logic [5:0] OFF_LAST  = 6'd43;

  localparam logic [3:0] KIND_DUTY     = 4'd0;
  localparam logic [3:0] KIND_HDR_OK   = 4'd1;
  localparam logic [3:0] KIND_HDR_RATE = 4'd2;
  localparam logic [3:0] KIND_NOT_RIFF = 4'd3;
  localparam logic [3:0] KIND_NOT_WAVE = 4'd4;
  localparam logic [3:0] KIND_NOT_PCM  = 4'd5;
  localparam logic [3:0] KIND_NOT_MONO = 4'd6;
  localparam logic [3:0] KIND_BAD_BITS = 4'd7;
  localparam logic [3:0] KIND_FIN      = 4'd8;

  localparam int          CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 1'd1;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
    logic       end_of_file;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  result_kind;
    logic [9:0]  duty_value;
    logic [30:0] sample_total;
    logic        last_of_run;
  } out_res_t;

  // One command: reps copies of a result, optionally followed by finished.
  typedef struct packed {
    logic [3:0]       kind;
    logic [9:0]       duty;
    logic [30:0]      total;
    logic [REP_W-1:0] reps;
    logic             fin;
  } cmd_t;

endpackage

/* rtl/wpd_front.sv */
// ---------------------------------------------------------------------------
// WAV header parser
// Takes one file byte per request, checks the header and turns samples into
// result commands for the emitter.
// ---------------------------------------------------------------------------
module wpd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept_i,
  input  wpd_pkg::in_req_t req_i,
  input  logic [31:0]     rate_i,
  input  logic [3:0]      repeat_i,
  output logic            cmd_push_o,
  output wpd_pkg::cmd_t   cmd_o
);
  import wpd_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  off_r, off_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic        mism_r, mism_nxt;
  logic [30:0] left_r, left_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        par_r, par_nxt;
  logic [3:0]  err_kind;
  logic [15:0] raw;
  logic [15:0] duty_full;
  logic [REP_W-1:0] reps;

  always_comb begin
    if (repeat_i == 4'd0) begin
      reps = REP_W'(1);
    end else if (int'(repeat_i) > MAX_REPEAT) begin
      reps = REP_W'(MAX_REPEAT);
    end else begin
      reps = REP_W'(repeat_i);
    end
  end

  assign raw       = {req_i.file_byte, hold_r};
  assign duty_full = (raw ^ 16'h8000) >> (16 - DUTY_BITS);

  always_comb begin
    phase_nxt  = phase_r;
    off_nxt    = off_r;
    shift_nxt  = shift_r;
    mism_nxt   = mism_r;
    left_nxt   = left_r;
    hold_nxt   = hold_r;
    par_nxt    = par_r;
    err_kind   = KIND_DUTY;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.reps = REP_W'(1);
    if (accept_i) begin
      if (req_i.start_of_file) begin
        phase_nxt = PH_HEADER;
        off_nxt   = '0;
        shift_nxt = '0;
        mism_nxt  = 1'b0;
        left_nxt  = '0;
        hold_nxt  = '0;
        par_nxt   = 1'b0;
      end
      case (phase_nxt)
        PH_HEADER: begin
          shift_nxt = {req_i.file_byte, shift_nxt[31:8]};
          case (off_nxt)
            OFF_RIFF: if (shift_nxt != TAG_RIFF) err_kind = KIND_NOT_RIFF;
            OFF_WAVE: if (shift_nxt != TAG_WAVE) err_kind = KIND_NOT_WAVE;
            OFF_FMT:  if (shift_nxt[31:16] != 16'd1) err_kind = KIND_NOT_PCM;
            OFF_CHAN: if (shift_nxt[31:16] != 16'd1) err_kind = KIND_NOT_MONO;
            OFF_RATE: mism_nxt = (shift_nxt != rate_i);
            OFF_BITS: if (shift_nxt[31:16] != 16'd16) err_kind = KIND_BAD_BITS;
            default:  err_kind = KIND_DUTY;
          endcase
          if (err_kind != KIND_DUTY) begin
            cmd_push_o = 1'b1;
            cmd_o.kind = err_kind;
            phase_nxt  = PH_DONE;
          end else if (off_nxt >= OFF_LAST) begin
            left_nxt    = shift_nxt[31:1];
            cmd_push_o  = 1'b1;
            cmd_o.kind  = mism_nxt ? KIND_HDR_RATE : KIND_HDR_OK;
            cmd_o.total = left_nxt;
            cmd_o.fin   = (left_nxt == '0) || req_i.end_of_file;
            par_nxt     = 1'b0;
            phase_nxt   = cmd_o.fin ? PH_DONE : PH_DATA;
          end else if (req_i.end_of_file) begin
            cmd_push_o = 1'b1;
            cmd_o.kind = KIND_BAD_BITS;
            phase_nxt  = PH_DONE;
          end else begin
            off_nxt = off_nxt + 6'd1;
          end
        end
        PH_DATA: begin
          if (!par_nxt) begin
            hold_nxt = req_i.file_byte;
            par_nxt  = 1'b1;
            if (req_i.end_of_file) begin
              cmd_push_o = 1'b1;
              cmd_o.kind = KIND_FIN;
              phase_nxt  = PH_DONE;
            end
          end else begin
            par_nxt    = 1'b0;
            left_nxt   = left_nxt - 31'd1;
            cmd_push_o = 1'b1;
            cmd_o.kind = KIND_DUTY;
            cmd_o.duty = duty_full[9:0];
            cmd_o.reps = reps;
            cmd_o.fin  = (left_nxt == '0) || req_i.end_of_file;
            if (cmd_o.fin) begin
              phase_nxt = PH_DONE;
            end
          end
        end
        default: begin
          phase_nxt = phase_nxt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      off_r   <= '0;
      shift_r <= '0;
      mism_r  <= 1'b0;
      left_r  <= '0;
      hold_r  <= '0;
      par_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      shift_r <= shift_nxt;
      mism_r  <= mism_nxt;
      left_r  <= left_nxt;
      hold_r  <= hold_nxt;
      par_r   <= par_nxt;
    end
  end

endmodule

/* rtl/wpd_cmd_fifo.sv */
// ---------------------------------------------------------------------------
// Command queue
// A short register queue that decouples the parser from the emitter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wpd_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  wpd_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output wpd_pkg::cmd_t data_o
);
  import wpd_pkg::*;

  cmd_t              mem_r [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_AW:0]   cnt_r;
  logic              do_push, do_pop;

  assign full_o  = (cnt_r == (CMD_AW+1)'(CMD_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign data_o  = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (CMD_AW+1)'(do_push) - (CMD_AW+1)'(do_pop);
    end
  end

  `WPD_ASSERT(a_cnt_bound, cnt_r <= (CMD_AW+1)'(CMD_DEPTH), "command queue count overflow")
  `WPD_ASSERT_IMPL(a_no_push_full, push_i, !full_o, "command pushed into a full queue")
  `WPD_ASSERT_IMPL(a_no_pop_empty, pop_i, !empty_o, "command popped from an empty queue")

endmodule

/* rtl/wpd_back.sv */
// ---------------------------------------------------------------------------
// Result emitter
// Expands each queued command into its results, one per cycle into an output
// register while that register is empty or being popped.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wpd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_empty_i,
  input  wpd_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             pop,
  output logic             empty,
  output wpd_pkg::out_res_t out_data
);
  import wpd_pkg::*;

  logic [REP_W-1:0] rep_idx_r, rep_idx_nxt;
  logic             fin_stg_r, fin_stg_nxt;
  logic             out_vld_r, out_vld_nxt;
  out_res_t         out_r, out_nxt;
  logic             adv;
  logic             last_copy;

  assign adv       = !cmd_empty_i && (!out_vld_r || pop);
  assign last_copy = (REP_W'(rep_idx_r + 1'b1) == cmd_i.reps);

  always_comb begin
    rep_idx_nxt = rep_idx_r;
    fin_stg_nxt = fin_stg_r;
    out_nxt     = out_r;
    cmd_pop_o   = 1'b0;
    out_vld_nxt = out_vld_r && !pop;
    if (adv) begin
      out_vld_nxt = 1'b1;
      if (fin_stg_r) begin
        out_nxt     = '{result_kind: KIND_FIN, duty_value: '0, sample_total: '0,
                        last_of_run: 1'b1};
        fin_stg_nxt = 1'b0;
        rep_idx_nxt = '0;
        cmd_pop_o   = 1'b1;
      end else begin
        out_nxt = '{result_kind: cmd_i.kind, duty_value: cmd_i.duty,
                    sample_total: cmd_i.total, last_of_run: last_copy && !cmd_i.fin};
        if (last_copy) begin
          rep_idx_nxt = '0;
          if (cmd_i.fin) begin
            fin_stg_nxt = 1'b1;
          end else begin
            cmd_pop_o = 1'b1;
          end
        end else begin
          rep_idx_nxt = rep_idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_idx_r <= '0;
      fin_stg_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rep_idx_r <= rep_idx_nxt;
      fin_stg_r <= fin_stg_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign empty    = !out_vld_r;
  assign out_data = out_r;

  `WPD_ASSERT_IMPL(a_fin_has_cmd, fin_stg_r, !cmd_empty_i, "finish stage without a command")
  `WPD_ASSERT_IMPL(a_idx_range, !cmd_empty_i, rep_idx_r < cmd_i.reps, "repeat index past count")

endmodule

/* rtl/wav_pcm_stream_to_pwm_duty.sv */
// ---------------------------------------------------------------------------
// WAV PCM stream to PWM duty
// Parses a mono 16-bit WAV byte stream and emits PWM duty values.
// ---------------------------------------------------------------------------
// The block takes one file byte per request and accepts a new byte in every
// cycle while its four-entry command queue has room. A header byte gives no
// result, except for the byte that fails a check or ends the file early,
// which gives one status. The last header byte gives the header status, plus
// a finished result when no samples follow. The first byte of a sample gives
// no result, or a finished result when the file ends there. The second byte
// gives repeat_count duty results, where zero acts as one and a count above
// eight acts as eight. It adds a finished result when the file ends there or
// the header's sample count runs out. Results leave the emitter at one per
// cycle while its output register is empty or being popped. The queue fills
// and raises full when bytes come faster than the emitter drains results.
// No clearing pass follows reset.
module wav_pcm_stream_to_pwm_duty (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  wpd_pkg::in_req_t                in_data,
  output logic                            empty,
  input  logic                            pop,
  output wpd_pkg::out_res_t               out_data,
  input  logic                            cfg_we,
  input  logic [wpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_wdata
);
  import wpd_pkg::*;

  logic [31:0] rate_r;
  logic [3:0]  repeat_r;
  logic        accept;
  logic        cmd_push, cmd_pop, cmd_empty;
  cmd_t        cmd_in, cmd_head;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= RATE_RESET;
      repeat_r <= REPEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE:   rate_r   <= cfg_wdata;
        REG_REPEAT: repeat_r <= cfg_wdata[3:0];
        default:    rate_r   <= rate_r;
      endcase
    end
  end

  wpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept_i   (accept),
    .req_i      (in_data),
    .rate_i     (rate_r),
    .repeat_i   (repeat_r),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  wpd_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_head)
  );

  wpd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_data    (out_data)
  );

endmodule
